// ===== hw/rtl/bcm_pkg.sv =====
`default_nettype none
package bcm_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int ACC_BITS_DEF = 48;

	localparam int GAIN_W     = 24;
	localparam int GAIN_FRAC  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_ACC_W  = 48;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_NODE1_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE2_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE3_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CUR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_HIGH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IMB_LIMIT     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 3'd7;

	localparam logic [GAIN_W-1:0] GAIN_RST       = 24'd279900;
	localparam logic [14:0]       ACTIVE_CUR_RST = 15'd50;
	localparam logic [15:0]       CELL_LOW_RST   = 16'd3000;
	localparam logic [15:0]       CELL_HIGH_RST  = 16'd4200;
	localparam logic [15:0]       IMB_LIMIT_RST  = 16'd100;
	localparam logic signed [11:0] TEMP_LIMIT_RST = 12'sd960;

	localparam logic [1:0] MODE_IDLE      = 2'd0;
	localparam logic [1:0] MODE_DISCHARGE = 2'd1;
	localparam logic [1:0] MODE_CHARGE    = 2'd2;

	// temperatures in 1/16 C
	localparam logic signed [11:0] TEMP_DEFAULT  = 12'sd400;
	localparam logic signed [11:0] TEMP_MIN_EXCL = -12'sd800;
	localparam logic signed [11:0] TEMP_MAX_EXCL = 12'sd2000;

	// mean by three: bias the sum positive, multiply by 2^16/3 rounded up
	localparam logic signed [13:0] MEAN_BIAS   = 14'sd2400;
	localparam logic signed [13:0] MEAN_OFFSET = 14'sd800;
	localparam logic [14:0]        RECIP3      = 15'd21846;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain1;
		logic [GAIN_W-1:0]  gain2;
		logic [GAIN_W-1:0]  gain3;
		logic [14:0]        active_cur;
		logic [15:0]        cell_low;
		logic [15:0]        cell_high;
		logic [15:0]        imb_limit;
		logic signed [11:0] temp_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [30:0]        chg_add;
		logic [31:0]        eng_add;
		logic signed [11:0] r1;
		logic signed [11:0] r2;
		logic signed [11:0] r3;
		logic               ok1;
		logic               ok2;
		logic               ok3;
		logic               none;
	} aux_t;

endpackage
`default_nettype wire

// ===== hw/rtl/battery_cell_monitor.sv =====
// Battery cell monitor: one telemetry sample in, one result out.
// Input channel in_valid/in_ready carries the sample fields; the result
// leaves on out_valid/out_ready. Registers are written through
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high
// and writes are expected only while no sample is in flight.
// Pipeline: an accepted sample sits in the input register, then passes the
// scaling/multiply stage and the result register before it is on the ports.
// Throughput: one sample per clock unless a stall backs up the pipeline; each
// stage holds one beat, and held temperatures and charge/energy accumulators
// update in the result stage, so back-to-back samples see each other's state.
// Reset: registers return to their defaults, held temperatures to 25 C,
// accumulators to zero, and the pipeline empties.
// Stall: while out_ready is low the result register holds; the two earlier
// stages keep filling, and in_ready drops once all three hold a beat.
`default_nettype none
module battery_cell_monitor #(
	parameter int ADC_BITS = bcm_pkg::ADC_BITS_DEF,
	parameter int ACC_BITS = bcm_pkg::ACC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [bcm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bcm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [ADC_BITS-1:0]                  node1_code,
	input  wire logic [ADC_BITS-1:0]                  node2_code,
	input  wire logic [ADC_BITS-1:0]                  node3_code,
	input  wire logic signed [15:0]                   pack_current,
	input  wire logic [15:0]                          pack_power,
	input  wire logic                                 current_ok,
	input  wire logic signed [11:0]                   probe1_raw,
	input  wire logic signed [11:0]                   probe2_raw,
	input  wire logic signed [11:0]                   probe3_raw,
	input  wire logic [1:0]                           probe_count,
	input  wire logic [15:0]                          elapsed_ms,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [15:0]                               cell1_mv,
	output logic [15:0]                               cell2_mv,
	output logic [15:0]                               cell3_mv,
	output logic [15:0]                               pack_mv,
	output logic [15:0]                               imbalance_mv,
	output logic signed [11:0]                        mean_temp,
	output logic [1:0]                                pack_mode,
	output logic [bcm_pkg::OUT_ACC_W-1:0]             charge_total,
	output logic [bcm_pkg::OUT_ACC_W-1:0]             energy_total,
	output logic                                      voltage_warn,
	output logic                                      imbalance_warn,
	output logic                                      temp_warn
);

	localparam int NODE_W = ADC_BITS + bcm_pkg::GAIN_W - bcm_pkg::GAIN_FRAC;

	bcm_pkg::cfg_t       cfg;
	bcm_pkg::aux_t       aux_s2;

	logic                vld_s1, vld_s2, vld_s3;
	logic                en2, en3, in_acc;

	logic [ADC_BITS-1:0] node1_s1, node2_s1, node3_s1;
	logic signed [15:0]  cur_s1;
	logic [15:0]         pwr_s1, ms_s1;
	logic                ok_s1;
	logic signed [11:0]  p1_s1, p2_s1, p3_s1;
	logic [1:0]          cnt_s1;

	logic [NODE_W-1:0]   node1_s2, node2_s2, node3_s2;

	// advance a stage when the next one is empty or moving
	assign en3      = vld_s2 && (!vld_s3 || out_ready);
	assign en2      = vld_s1 && (!vld_s2 || en3);
	assign in_ready = !vld_s1 || en2;
	assign in_acc   = in_valid && in_ready;

	assign cfg_ready = 1'b1;
	assign out_valid = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (en2) begin
				vld_s1 <= 1'b0;
			end
			if (en2) begin
				vld_s2 <= 1'b1;
			end else if (en3) begin
				vld_s2 <= 1'b0;
			end
			if (en3) begin
				vld_s3 <= 1'b1;
			end else if (out_ready) begin
				vld_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			node1_s1 <= node1_code;
			node2_s1 <= node2_code;
			node3_s1 <= node3_code;
			cur_s1   <= pack_current;
			pwr_s1   <= pack_power;
			ok_s1    <= current_ok;
			p1_s1    <= probe1_raw;
			p2_s1    <= probe2_raw;
			p3_s1    <= probe3_raw;
			cnt_s1   <= probe_count;
			ms_s1    <= elapsed_ms;
		end
	end

	bcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	bcm_front #(
		.ADC_BITS (ADC_BITS),
		.NODE_W   (NODE_W)
	) u_front (
		.clk          (clk),
		.en           (en2),
		.cfg          (cfg),
		.node1_code   (node1_s1),
		.node2_code   (node2_s1),
		.node3_code   (node3_s1),
		.pack_current (cur_s1),
		.pack_power   (pwr_s1),
		.current_ok   (ok_s1),
		.probe1_raw   (p1_s1),
		.probe2_raw   (p2_s1),
		.probe3_raw   (p3_s1),
		.probe_count  (cnt_s1),
		.elapsed_ms   (ms_s1),
		.node1_s2     (node1_s2),
		.node2_s2     (node2_s2),
		.node3_s2     (node3_s2),
		.aux_s2       (aux_s2)
	);

	bcm_back #(
		.ADC_BITS (ADC_BITS),
		.ACC_BITS (ACC_BITS),
		.NODE_W   (NODE_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en3),
		.cfg       (cfg),
		.node1_s2  (node1_s2),
		.node2_s2  (node2_s2),
		.node3_s2  (node3_s2),
		.aux_s2    (aux_s2),
		.cell1_s3  (cell1_mv),
		.cell2_s3  (cell2_mv),
		.cell3_s3  (cell3_mv),
		.pack_s3   (pack_mv),
		.imb_s3    (imbalance_mv),
		.mean_s3   (mean_temp),
		.mode_s3   (pack_mode),
		.charge_s3 (charge_total),
		.energy_s3 (energy_total),
		.vwarn_s3  (voltage_warn),
		.iwarn_s3  (imbalance_warn),
		.twarn_s3  (temp_warn)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/bcm_cfg.sv =====
`default_nettype none
module bcm_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bcm_pkg::CFG_IDX_W-1:0]  wr_idx,
	input  wire logic [bcm_pkg::CFG_DATA_W-1:0] wr_data,
	output bcm_pkg::cfg_t                       cfg
);

	bcm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain1      <= bcm_pkg::GAIN_RST;
			cfg_q.gain2      <= bcm_pkg::GAIN_RST;
			cfg_q.gain3      <= bcm_pkg::GAIN_RST;
			cfg_q.active_cur <= bcm_pkg::ACTIVE_CUR_RST;
			cfg_q.cell_low   <= bcm_pkg::CELL_LOW_RST;
			cfg_q.cell_high  <= bcm_pkg::CELL_HIGH_RST;
			cfg_q.imb_limit  <= bcm_pkg::IMB_LIMIT_RST;
			cfg_q.temp_limit <= bcm_pkg::TEMP_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_idx)
				bcm_pkg::REG_NODE1_GAIN: cfg_q.gain1      <= wr_data;
				bcm_pkg::REG_NODE2_GAIN: cfg_q.gain2      <= wr_data;
				bcm_pkg::REG_NODE3_GAIN: cfg_q.gain3      <= wr_data;
				bcm_pkg::REG_ACTIVE_CUR: cfg_q.active_cur <= wr_data[14:0];
				bcm_pkg::REG_CELL_LOW:   cfg_q.cell_low   <= wr_data[15:0];
				bcm_pkg::REG_CELL_HIGH:  cfg_q.cell_high  <= wr_data[15:0];
				bcm_pkg::REG_IMB_LIMIT:  cfg_q.imb_limit  <= wr_data[15:0];
				bcm_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit <= $signed(wr_data[11:0]);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bcm_front.sv =====
`default_nettype none
module bcm_front #(
	parameter int ADC_BITS = bcm_pkg::ADC_BITS_DEF,
	parameter int NODE_W   = ADC_BITS + bcm_pkg::GAIN_W - bcm_pkg::GAIN_FRAC
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire bcm_pkg::cfg_t       cfg,
	input  wire logic [ADC_BITS-1:0] node1_code,
	input  wire logic [ADC_BITS-1:0] node2_code,
	input  wire logic [ADC_BITS-1:0] node3_code,
	input  wire logic signed [15:0]  pack_current,
	input  wire logic [15:0]         pack_power,
	input  wire logic                current_ok,
	input  wire logic signed [11:0]  probe1_raw,
	input  wire logic signed [11:0]  probe2_raw,
	input  wire logic signed [11:0]  probe3_raw,
	input  wire logic [1:0]          probe_count,
	input  wire logic [15:0]         elapsed_ms,
	output logic [NODE_W-1:0]        node1_s2,
	output logic [NODE_W-1:0]        node2_s2,
	output logic [NODE_W-1:0]        node3_s2,
	output bcm_pkg::aux_t            aux_s2
);

	localparam int PROD_W = ADC_BITS + bcm_pkg::GAIN_W;

	logic [PROD_W-1:0]   prod1, prod2, prod3;
	logic signed [15:0]  cur;
	logic [15:0]         pwr;
	logic signed [16:0]  cur_x, act_x;
	bcm_pkg::aux_t       aux;

	assign prod1 = {{bcm_pkg::GAIN_W{1'b0}}, node1_code} * {{ADC_BITS{1'b0}}, cfg.gain1};
	assign prod2 = {{bcm_pkg::GAIN_W{1'b0}}, node2_code} * {{ADC_BITS{1'b0}}, cfg.gain2};
	assign prod3 = {{bcm_pkg::GAIN_W{1'b0}}, node3_code} * {{ADC_BITS{1'b0}}, cfg.gain3};

	assign cur   = current_ok ? pack_current : 16'sd0;
	assign pwr   = current_ok ? pack_power : 16'd0;
	assign cur_x = {cur[15], cur};
	assign act_x = $signed({2'b00, cfg.active_cur});

	always_comb begin
		aux = '0;
		if (cur_x > act_x) begin
			aux.mode = bcm_pkg::MODE_DISCHARGE;
		end else if (cur_x < -act_x) begin
			aux.mode = bcm_pkg::MODE_CHARGE;
		end else begin
			aux.mode = bcm_pkg::MODE_IDLE;
		end
		// only used in discharge, where the current is known positive
		aux.chg_add = {16'd0, cur[14:0]} * {15'd0, elapsed_ms};
		aux.eng_add = {16'd0, pwr} * {16'd0, elapsed_ms};
		// missing probes copy probe one
		aux.r1 = probe1_raw;
		aux.r2 = (probe_count > 2'd1) ? probe2_raw : probe1_raw;
		aux.r3 = (probe_count > 2'd2) ? probe3_raw : probe1_raw;
		aux.ok1 = (aux.r1 > bcm_pkg::TEMP_MIN_EXCL) && (aux.r1 < bcm_pkg::TEMP_MAX_EXCL);
		aux.ok2 = (aux.r2 > bcm_pkg::TEMP_MIN_EXCL) && (aux.r2 < bcm_pkg::TEMP_MAX_EXCL);
		aux.ok3 = (aux.r3 > bcm_pkg::TEMP_MIN_EXCL) && (aux.r3 < bcm_pkg::TEMP_MAX_EXCL);
		aux.none = (probe_count == 2'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node1_s2 <= prod1[PROD_W-1:bcm_pkg::GAIN_FRAC];
			node2_s2 <= prod2[PROD_W-1:bcm_pkg::GAIN_FRAC];
			node3_s2 <= prod3[PROD_W-1:bcm_pkg::GAIN_FRAC];
			aux_s2   <= aux;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bcm_back.sv =====
`default_nettype none
module bcm_back #(
	parameter int ADC_BITS = bcm_pkg::ADC_BITS_DEF,
	parameter int ACC_BITS = bcm_pkg::ACC_BITS_DEF,
	parameter int NODE_W   = ADC_BITS + bcm_pkg::GAIN_W - bcm_pkg::GAIN_FRAC
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire bcm_pkg::cfg_t                   cfg,
	input  wire logic [NODE_W-1:0]               node1_s2,
	input  wire logic [NODE_W-1:0]               node2_s2,
	input  wire logic [NODE_W-1:0]               node3_s2,
	input  wire bcm_pkg::aux_t                   aux_s2,
	output logic [15:0]                          cell1_s3,
	output logic [15:0]                          cell2_s3,
	output logic [15:0]                          cell3_s3,
	output logic [15:0]                          pack_s3,
	output logic [15:0]                          imb_s3,
	output logic signed [11:0]                   mean_s3,
	output logic [1:0]                           mode_s3,
	output logic [bcm_pkg::OUT_ACC_W-1:0]        charge_s3,
	output logic [bcm_pkg::OUT_ACC_W-1:0]        energy_s3,
	output logic                                 vwarn_s3,
	output logic                                 iwarn_s3,
	output logic                                 twarn_s3
);

	function automatic logic [15:0] sat16(input logic [NODE_W-1:0] v);
		logic [15:0] r;
		r = (v > NODE_W'(65535)) ? 16'hFFFF : v[15:0];
		return r;
	endfunction

	function automatic logic [bcm_pkg::OUT_ACC_W-1:0] sat_out(input logic [ACC_BITS-1:0] a);
		logic [63:0] w;
		w = 64'(a);
		return (|w[63:bcm_pkg::OUT_ACC_W]) ? '1 : w[bcm_pkg::OUT_ACC_W-1:0];
	endfunction

	logic [NODE_W-1:0]   d2, d3;
	logic [15:0]         c1, c2, c3, mn, mx, imb;
	logic                vw, tw;

	logic signed [11:0]  held1_q, held2_q, held3_q;
	logic signed [11:0]  nh1, nh2, nh3;
	logic signed [13:0]  tsum, tbias, mean_w;
	logic [28:0]         tprod;

	logic [ACC_BITS-1:0] charge_q, energy_q, charge_nx, energy_nx;
	logic [ACC_BITS:0]   charge_sum, energy_sum;
	logic                dis;

	// cells are node differences, clamped at zero
	assign d2 = (node2_s2 > node1_s2) ? node2_s2 - node1_s2 : '0;
	assign d3 = (node3_s2 > node2_s2) ? node3_s2 - node2_s2 : '0;
	assign c1 = sat16(node1_s2);
	assign c2 = sat16(d2);
	assign c3 = sat16(d3);

	always_comb begin
		mn = c1;
		mx = c1;
		if (c2 < mn) mn = c2;
		if (c3 < mn) mn = c3;
		if (c2 > mx) mx = c2;
		if (c3 > mx) mx = c3;
	end
	assign imb = mx - mn;

	assign vw = (c1 < cfg.cell_low) || (c1 > cfg.cell_high) ||
		(c2 < cfg.cell_low) || (c2 > cfg.cell_high) ||
		(c3 < cfg.cell_low) || (c3 > cfg.cell_high);

	// hold the last in-range reading per probe; a probe count of zero restores the default
	assign nh1 = aux_s2.none ? bcm_pkg::TEMP_DEFAULT : (aux_s2.ok1 ? aux_s2.r1 : held1_q);
	assign nh2 = aux_s2.none ? bcm_pkg::TEMP_DEFAULT : (aux_s2.ok2 ? aux_s2.r2 : held2_q);
	assign nh3 = aux_s2.none ? bcm_pkg::TEMP_DEFAULT : (aux_s2.ok3 ? aux_s2.r3 : held3_q);

	assign tw = (nh1 > cfg.temp_limit) || (nh2 > cfg.temp_limit) || (nh3 > cfg.temp_limit);

	// floor division by three on a biased, non-negative sum
	assign tsum   = 14'(nh1) + 14'(nh2) + 14'(nh3);
	assign tbias  = tsum + bcm_pkg::MEAN_BIAS;
	assign tprod  = {15'd0, tbias} * {14'd0, bcm_pkg::RECIP3};
	assign mean_w = $signed({1'b0, tprod[28:16]}) - bcm_pkg::MEAN_OFFSET;

	assign dis = (aux_s2.mode == bcm_pkg::MODE_DISCHARGE);

	assign charge_sum = {1'b0, charge_q} + (ACC_BITS+1)'(aux_s2.chg_add);
	assign energy_sum = {1'b0, energy_q} + (ACC_BITS+1)'(aux_s2.eng_add);

	always_comb begin
		charge_nx = charge_q;
		energy_nx = energy_q;
		if (dis) begin
			charge_nx = charge_sum[ACC_BITS] ? '1 : charge_sum[ACC_BITS-1:0];
			energy_nx = energy_sum[ACC_BITS] ? '1 : energy_sum[ACC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held1_q  <= bcm_pkg::TEMP_DEFAULT;
			held2_q  <= bcm_pkg::TEMP_DEFAULT;
			held3_q  <= bcm_pkg::TEMP_DEFAULT;
			charge_q <= '0;
			energy_q <= '0;
		end else if (en) begin
			held1_q  <= nh1;
			held2_q  <= nh2;
			held3_q  <= nh3;
			charge_q <= charge_nx;
			energy_q <= energy_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell1_s3  <= c1;
			cell2_s3  <= c2;
			cell3_s3  <= c3;
			pack_s3   <= sat16(node3_s2);
			imb_s3    <= imb;
			mean_s3   <= mean_w[11:0];
			mode_s3   <= aux_s2.mode;
			charge_s3 <= sat_out(charge_nx);
			energy_s3 <= sat_out(energy_nx);
			vwarn_s3  <= vw;
			iwarn_s3  <= (imb > cfg.imb_limit);
			twarn_s3  <= tw;
		end
	end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

	localparam int QUIET_LIMIT   = 1000;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_CYCLES  = 4;
	localparam int FULL_BURST    = 200;

	localparam bcm_pkg::cfg_t DEFAULT_SETTINGS = '{
		gain1: bcm_pkg::GAIN_RST, gain2: bcm_pkg::GAIN_RST, gain3: bcm_pkg::GAIN_RST,
		active_cur: bcm_pkg::ACTIVE_CUR_RST,
		cell_low: bcm_pkg::CELL_LOW_RST, cell_high: bcm_pkg::CELL_HIGH_RST,
		imb_limit: bcm_pkg::IMB_LIMIT_RST, temp_limit: bcm_pkg::TEMP_LIMIT_RST
	};

	typedef struct {
		logic [11:0]        node1;
		logic [11:0]        node2;
		logic [11:0]        node3;
		logic signed [15:0] current;
		logic [15:0]        power;
		logic               current_ok;
		logic signed [11:0] probe1;
		logic signed [11:0] probe2;
		logic signed [11:0] probe3;
		logic [1:0]         probe_count;
		logic [15:0]        elapsed;
	} sample_t;

	typedef struct {
		logic [15:0]        cell1_mv;
		logic [15:0]        cell2_mv;
		logic [15:0]        cell3_mv;
		logic [15:0]        pack_mv;
		logic [15:0]        imbalance_mv;
		logic signed [11:0] mean_temp;
		logic [1:0]         pack_mode;
		logic [47:0]        charge_total;
		logic [47:0]        energy_total;
		logic               voltage_warn;
		logic               imbalance_warn;
		logic               temp_warn;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [11:0] node1_code = '0;
	logic [11:0] node2_code = '0;
	logic [11:0] node3_code = '0;
	logic signed [15:0] pack_current = '0;
	logic [15:0] pack_power = '0;
	logic current_ok = 1'b0;
	logic signed [11:0] probe1_raw = '0;
	logic signed [11:0] probe2_raw = '0;
	logic signed [11:0] probe3_raw = '0;
	logic [1:0] probe_count = '0;
	logic [15:0] elapsed_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] cell1_mv, cell2_mv, cell3_mv, pack_mv, imbalance_mv;
	logic signed [11:0] mean_temp;
	logic [1:0] pack_mode;
	logic [bcm_pkg::OUT_ACC_W-1:0] charge_total, energy_total;
	logic voltage_warn, imbalance_warn, temp_warn;

	// predictor state and register copy
	bcm_pkg::cfg_t regs;
	logic signed [11:0] probe_hold [3];
	logic [47:0] drawn_charge;
	logic [47:0] drawn_energy;

	report_t pending_reports [$];
	int mismatches = 0;
	int samples_sent = 0;
	int reports_checked = 0;
	int settings_used = 1;
	int quiet_cycles = 0;
	bit steady_flow = 1'b0;
	bit hold_results = 1'b0;

	battery_cell_monitor u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.node1_code(node1_code), .node2_code(node2_code), .node3_code(node3_code),
		.pack_current(pack_current), .pack_power(pack_power), .current_ok(current_ok),
		.probe1_raw(probe1_raw), .probe2_raw(probe2_raw), .probe3_raw(probe3_raw),
		.probe_count(probe_count), .elapsed_ms(elapsed_ms),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell1_mv(cell1_mv), .cell2_mv(cell2_mv), .cell3_mv(cell3_mv),
		.pack_mv(pack_mv), .imbalance_mv(imbalance_mv), .mean_temp(mean_temp),
		.pack_mode(pack_mode), .charge_total(charge_total), .energy_total(energy_total),
		.voltage_warn(voltage_warn), .imbalance_warn(imbalance_warn),
		.temp_warn(temp_warn)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] clamp16(input logic [39:0] v);
		return (v > 40'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [47:0] add_saturated(input logic [47:0] acc,
			input logic [47:0] add);
		logic [48:0] total;
		total = {1'b0, acc} + {1'b0, add};
		return total[48] ? '1 : total[47:0];
	endfunction

	function automatic report_t predict_telemetry(input sample_t smp);
		report_t r;
		logic [39:0] n1, n2, n3;
		logic [15:0] lo, hi, pwr;
		logic signed [11:0] lim;
		int rd [3];
		int sum, mean, cur, act;
		n1 = (40'(smp.node1) * 40'(regs.gain1)) >> bcm_pkg::GAIN_FRAC;
		n2 = (40'(smp.node2) * 40'(regs.gain2)) >> bcm_pkg::GAIN_FRAC;
		n3 = (40'(smp.node3) * 40'(regs.gain3)) >> bcm_pkg::GAIN_FRAC;
		r.cell1_mv = clamp16(n1);
		r.cell2_mv = clamp16(n2 > n1 ? n2 - n1 : 40'd0);
		r.cell3_mv = clamp16(n3 > n2 ? n3 - n2 : 40'd0);
		r.pack_mv = clamp16(n3);
		lo = r.cell1_mv;
		hi = r.cell1_mv;
		if (r.cell2_mv < lo) lo = r.cell2_mv;
		if (r.cell3_mv < lo) lo = r.cell3_mv;
		if (r.cell2_mv > hi) hi = r.cell2_mv;
		if (r.cell3_mv > hi) hi = r.cell3_mv;
		r.imbalance_mv = hi - lo;

		if (smp.probe_count == 2'd0) begin
			foreach (probe_hold[i]) probe_hold[i] = bcm_pkg::TEMP_DEFAULT;
		end else begin
			// missing probes read probe one
			rd[0] = int'(smp.probe1);
			rd[1] = (smp.probe_count > 2'd1) ? int'(smp.probe2) : int'(smp.probe1);
			rd[2] = (smp.probe_count > 2'd2) ? int'(smp.probe3) : int'(smp.probe1);
			foreach (rd[i])
				if (rd[i] > int'(bcm_pkg::TEMP_MIN_EXCL) &&
						rd[i] < int'(bcm_pkg::TEMP_MAX_EXCL))
					probe_hold[i] = 12'(rd[i]);
		end
		sum = int'(probe_hold[0]) + int'(probe_hold[1]) + int'(probe_hold[2]);
		mean = (sum >= 0) ? sum / 3 : -((-sum + 2) / 3);
		r.mean_temp = 12'(mean);

		cur = smp.current_ok ? int'(smp.current) : 0;
		pwr = smp.current_ok ? smp.power : 16'd0;
		act = int'(regs.active_cur);
		if (cur > act) begin
			r.pack_mode = bcm_pkg::MODE_DISCHARGE;
			drawn_charge = add_saturated(drawn_charge, 48'(cur) * 48'(smp.elapsed));
			drawn_energy = add_saturated(drawn_energy, 48'(pwr) * 48'(smp.elapsed));
		end else if (cur < -act) begin
			r.pack_mode = bcm_pkg::MODE_CHARGE;
		end else begin
			r.pack_mode = bcm_pkg::MODE_IDLE;
		end
		r.charge_total = drawn_charge;
		r.energy_total = drawn_energy;

		r.voltage_warn = r.cell1_mv < regs.cell_low || r.cell1_mv > regs.cell_high ||
			r.cell2_mv < regs.cell_low || r.cell2_mv > regs.cell_high ||
			r.cell3_mv < regs.cell_low || r.cell3_mv > regs.cell_high;
		r.imbalance_warn = r.imbalance_mv > regs.imb_limit;
		lim = regs.temp_limit;
		r.temp_warn = probe_hold[0] > lim || probe_hold[1] > lim || probe_hold[2] > lim;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	function automatic sample_t nominal_sample();
		sample_t smp;
		smp.node1 = 12'd850;
		smp.node2 = 12'd1700;
		smp.node3 = 12'd2550;
		smp.current = 16'sd0;
		smp.power = 16'd0;
		smp.current_ok = 1'b1;
		smp.probe1 = 12'sd400;
		smp.probe2 = 12'sd400;
		smp.probe3 = 12'sd400;
		smp.probe_count = 2'd3;
		smp.elapsed = 16'd1000;
		return smp;
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		int mag, v;
		if ($urandom_range(0, 9) < 7) begin
			// plausible pack: rising nodes, moderate current, probes near room temp
			smp.node1 = 12'($urandom_range(650, 1000));
			smp.node2 = smp.node1 + 12'($urandom_range(650, 1000));
			smp.node3 = smp.node2 + 12'($urandom_range(650, 1000));
			mag = $urandom_range(0, 4000);
			smp.current = 16'($urandom_range(0, 1) ? mag : -mag);
			smp.power = 16'(mag * $urandom_range(9, 13));
			smp.current_ok = ($urandom_range(0, 19) != 0);
			smp.probe1 = 12'($urandom_range(0, 1100));
			smp.probe2 = 12'($urandom_range(0, 1100));
			smp.probe3 = 12'($urandom_range(0, 1100));
			if ($urandom_range(0, 7) == 0) begin
				v = $urandom_range(790, 2048);
				smp.probe2 = 12'(-v);
			end
			if ($urandom_range(0, 7) == 0)
				smp.probe3 = 12'($urandom_range(1990, 2047));
			smp.probe_count = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 2)) : 2'd3;
			smp.elapsed = 16'($urandom_range(50, 2000));
		end else begin
			smp.node1 = 12'($urandom);
			smp.node2 = 12'($urandom);
			smp.node3 = 12'($urandom);
			smp.current = 16'($urandom);
			smp.power = 16'($urandom);
			smp.current_ok = 1'($urandom);
			smp.probe1 = 12'($urandom);
			smp.probe2 = 12'($urandom);
			smp.probe3 = 12'($urandom);
			smp.probe_count = 2'($urandom);
			smp.elapsed = 16'($urandom);
		end
		return smp;
	endfunction

	function automatic bcm_pkg::cfg_t random_settings();
		bcm_pkg::cfg_t c;
		if ($urandom_range(0, 3) == 0) begin
			c.gain1 = 24'($urandom);
			c.gain2 = 24'($urandom);
			c.gain3 = 24'($urandom);
			c.active_cur = 15'($urandom);
			c.cell_low = 16'($urandom);
			c.cell_high = 16'($urandom);
			c.imb_limit = 16'($urandom);
			c.temp_limit = 12'($urandom);
		end else begin
			c.gain1 = 24'($urandom_range(260000, 300000));
			c.gain2 = 24'($urandom_range(260000, 300000));
			c.gain3 = 24'($urandom_range(260000, 300000));
			c.active_cur = 15'($urandom_range(0, 500));
			c.cell_low = 16'($urandom_range(2800, 3300));
			c.cell_high = 16'($urandom_range(3900, 4400));
			c.imb_limit = 16'($urandom_range(20, 400));
			c.temp_limit = 12'($urandom_range(300, 1100));
		end
		return c;
	endfunction

	task automatic send_sample(input sample_t smp);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		node1_code <= smp.node1;
		node2_code <= smp.node2;
		node3_code <= smp.node3;
		pack_current <= smp.current;
		pack_power <= smp.power;
		current_ok <= smp.current_ok;
		probe1_raw <= smp.probe1;
		probe2_raw <= smp.probe2;
		probe3_raw <= smp.probe3;
		probe_count <= smp.probe_count;
		elapsed_ms <= smp.elapsed;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		pending_reports.push_back(predict_telemetry(smp));
		samples_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bcm_pkg::CFG_IDX_W-1:0] idx,
			input logic [bcm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		case (idx)
			bcm_pkg::REG_NODE1_GAIN: regs.gain1 = data;
			bcm_pkg::REG_NODE2_GAIN: regs.gain2 = data;
			bcm_pkg::REG_NODE3_GAIN: regs.gain3 = data;
			bcm_pkg::REG_ACTIVE_CUR: regs.active_cur = data[14:0];
			bcm_pkg::REG_CELL_LOW: regs.cell_low = data[15:0];
			bcm_pkg::REG_CELL_HIGH: regs.cell_high = data[15:0];
			bcm_pkg::REG_IMB_LIMIT: regs.imb_limit = data[15:0];
			bcm_pkg::REG_TEMP_LIMIT: regs.temp_limit = data[11:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(input bcm_pkg::cfg_t c);
		wait_idle();
		write_reg(bcm_pkg::REG_NODE1_GAIN, c.gain1);
		write_reg(bcm_pkg::REG_NODE2_GAIN, c.gain2);
		write_reg(bcm_pkg::REG_NODE3_GAIN, c.gain3);
		write_reg(bcm_pkg::REG_ACTIVE_CUR, bcm_pkg::CFG_DATA_W'(c.active_cur));
		write_reg(bcm_pkg::REG_CELL_LOW, bcm_pkg::CFG_DATA_W'(c.cell_low));
		write_reg(bcm_pkg::REG_CELL_HIGH, bcm_pkg::CFG_DATA_W'(c.cell_high));
		write_reg(bcm_pkg::REG_IMB_LIMIT, bcm_pkg::CFG_DATA_W'(c.imb_limit));
		write_reg(bcm_pkg::REG_TEMP_LIMIT, bcm_pkg::CFG_DATA_W'(c.temp_limit));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// runs on the registers as they come out of reset
	task automatic test_reset_defaults();
		sample_t smp;
		smp = nominal_sample();
		send_sample(smp);
		smp.node1 = 12'd0; smp.node2 = 12'd0; smp.node3 = 12'd0; smp.elapsed = 16'd0;
		send_sample(smp);
		smp.node1 = 12'hFFF; smp.node2 = 12'hFFF; smp.node3 = 12'hFFF;
		send_sample(smp);
		// falling nodes clamp the upper cells
		smp.node1 = 12'd3000; smp.node2 = 12'd2000; smp.node3 = 12'd1000;
		send_sample(smp);
		smp = nominal_sample();
		smp.node2 = 12'd2000; smp.node3 = 12'd2100;
		send_sample(smp);
		// activity threshold on both sides
		smp = nominal_sample();
		smp.current = 16'sd50;
		send_sample(smp);
		smp.current = 16'sd51; smp.power = 16'hFFFF; smp.elapsed = 16'hFFFF;
		send_sample(smp);
		smp.current = -16'sd50;
		send_sample(smp);
		smp.current = -16'sd51;
		send_sample(smp);
		smp.current = 16'sh7FFF; smp.current_ok = 1'b0;
		send_sample(smp);
		smp.current = 16'sh8000; smp.current_ok = 1'b1;
		send_sample(smp);
		smp.current = 16'sh7FFF;
		send_sample(smp);
		// probe handling: count zero, missing probes, out of range readings
		smp = nominal_sample();
		smp.probe1 = 12'sd100; smp.probe2 = 12'sd200; smp.probe3 = 12'sd300;
		send_sample(smp);
		smp.probe_count = 2'd0; smp.probe1 = 12'h800; smp.probe2 = 12'sd1500;
		send_sample(smp);
		smp.probe_count = 2'd1; smp.probe1 = 12'sd500; smp.probe2 = 12'h800;
		smp.probe3 = 12'sh7FF;
		send_sample(smp);
		smp.probe_count = 2'd2; smp.probe1 = 12'sd600; smp.probe2 = 12'sd700;
		smp.probe3 = 12'sd10;
		send_sample(smp);
		smp.probe_count = 2'd3; smp.probe1 = -12'sd800; smp.probe2 = 12'sd2000;
		smp.probe3 = 12'h800;
		send_sample(smp);
		smp.probe1 = -12'sd799; smp.probe2 = 12'sd1999; smp.probe3 = 12'sh7FF;
		send_sample(smp);
		smp.probe1 = 12'sd960; smp.probe2 = 12'sd960; smp.probe3 = 12'sd961;
		send_sample(smp);
		smp.probe1 = -12'sd799; smp.probe2 = -12'sd799; smp.probe3 = -12'sd798;
		send_sample(smp);
	endtask

	task automatic test_register_extremes();
		bcm_pkg::cfg_t c;
		sample_t smp;
		c = '{gain1: '1, gain2: '1, gain3: '1, active_cur: '0, cell_low: '0,
			cell_high: '0, imb_limit: '0, temp_limit: 12'h800};
		write_settings(c);
		smp = nominal_sample();
		smp.node1 = 12'hFFF; smp.node2 = 12'hFFF; smp.node3 = 12'hFFF;
		smp.current = 16'sd1;
		send_sample(smp);
		smp.node2 = 12'd0; smp.current = -16'sd1;
		send_sample(smp);
		smp.current = 16'sd0;
		send_sample(smp);
		repeat (150) send_sample(random_sample());

		c = '{gain1: '0, gain2: '0, gain3: '0, active_cur: '1, cell_low: '1,
			cell_high: '1, imb_limit: '1, temp_limit: 12'h7FF};
		write_settings(c);
		smp = nominal_sample();
		smp.current = 16'sh8000;
		send_sample(smp);
		smp.current = 16'sh7FFF;
		send_sample(smp);
		repeat (150) send_sample(random_sample());
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			write_settings(phase == 0 ? DEFAULT_SETTINGS : random_settings());
			repeat (210) send_sample(random_sample());
		end
	endtask

	// stall results long enough that the input backs up, then drain fully and resume
	task automatic test_backpressure();
		wait_idle();
		steady_flow = 1'b1;
		hold_results = 1'b1;
		repeat (24) send_sample(random_sample());
		steady_flow = 1'b0;
		wait_idle();
		repeat (30) send_sample(random_sample());
	endtask

	// full-scale discharge back to back, so both totals grow by their largest steps
	task automatic test_full_scale_discharge();
		sample_t smp;
		write_settings(DEFAULT_SETTINGS);
		smp = nominal_sample();
		smp.current = 16'sh7FFF;
		smp.power = 16'hFFFF;
		smp.elapsed = 16'hFFFF;
		steady_flow = 1'b1;
		repeat (FULL_BURST) send_sample(smp);
		steady_flow = 1'b0;
		repeat (20) send_sample(random_sample());
	endtask

	initial begin : result_checker
		int stall;
		report_t want;
		forever begin
			if (hold_results) begin
				hold_results = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = steady_flow ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (pending_reports.size() == 0) begin
				$error("result beat with no sample outstanding");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				check_field("cell1_mv", want.cell1_mv, cell1_mv);
				check_field("cell2_mv", want.cell2_mv, cell2_mv);
				check_field("cell3_mv", want.cell3_mv, cell3_mv);
				check_field("pack_mv", want.pack_mv, pack_mv);
				check_field("imbalance_mv", want.imbalance_mv, imbalance_mv);
				check_field("mean_temp", want.mean_temp, mean_temp);
				check_field("pack_mode", want.pack_mode, pack_mode);
				check_field("charge_total", want.charge_total, charge_total);
				check_field("energy_total", want.energy_total, energy_total);
				check_field("voltage_warn", want.voltage_warn, voltage_warn);
				check_field("imbalance_warn", want.imbalance_warn, imbalance_warn);
				check_field("temp_warn", want.temp_warn, temp_warn);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready === 1'b1) || (out_ready && out_valid === 1'b1) ||
				(cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		regs = DEFAULT_SETTINGS;
		foreach (probe_hold[i]) probe_hold[i] = bcm_pkg::TEMP_DEFAULT;
		drawn_charge = '0;
		drawn_energy = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		test_full_scale_discharge();

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Summary: %0d samples sent, %0d results checked, %0d register settings.",
			samples_sent, reports_checked, settings_used);
		$display("Covered cell clamping, probe counts, all pack modes, stalls and full-scale discharge.");
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
